[sv/mclp_pkg.sv]
// Shared types, codes and constants for the multi-channel LED mode PWM block.
package mclp_pkg;

    // Default sizes handed to the top level.
    localparam int CHANNELS_DEF   = 8;
    localparam int PWM_LEVELS_DEF = 32;

    // Fixed field and register widths.
    localparam int REQ_W      = 2;
    localparam int CHAN_SEL_W = 4;
    localparam int MODE_W     = 2;
    localparam int DRIVE_W    = 8;
    localparam int LEVEL_IN_W = 5;
    localparam int TIME_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SAT_W      = 9;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_SET_ONE = 2'd0,
        REQ_SET_ALL = 2'd1,
        REQ_MS_TICK = 2'd2,
        REQ_PWM     = 2'd3
    } t_req;

    // Channel mode codes.
    typedef enum logic [MODE_W-1:0] {
        MODE_ACTIVE   = 2'd0,
        MODE_INACTIVE = 2'd1,
        MODE_SINGLE   = 2'd2,
        MODE_REPEAT   = 2'd3
    } t_mode;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ACTIVE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_INACTIVE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_FLASH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_MS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_MS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POLARITY       = 3'd5;

    // Input word.
    typedef struct packed {
        logic [REQ_W-1:0]      req_type;
        logic [CHAN_SEL_W-1:0] chan_sel;
        logic [MODE_W-1:0]     new_mode;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [DRIVE_W-1:0] led_drive;
        logic [MODE_W-1:0]  chan_mode;
    } t_out_word;

    // Clamp a written level to the top PWM level.
    function automatic logic [SAT_W-1:0] sat_level(input logic [LEVEL_IN_W-1:0] v,
                                                   input logic [SAT_W-1:0] top);
        logic [SAT_W-1:0] ext;
        ext = {{(SAT_W-LEVEL_IN_W){1'b0}}, v};
        return (ext > top) ? top : ext;
    endfunction

endpackage

[sv/multi_channel_led_mode_pwm.sv]
// Top level of the multi-channel LED mode controller with software PWM.
//
// Usage: the input channel (i_in_valid, o_in_stall, i_in) carries one word per
// request: set one channel's mode, set every channel's mode, a millisecond tick
// or a PWM tick. Every accepted word yields exactly one result word on the
// output channel (o_out_valid, i_out_stall, o_out) holding the LED drive bits
// and the mode of the selected channel after the update.
// The state updates at the edge that accepts the word, and its result enters the
// result register, or the skid register if a result still waits. One word is
// taken every cycle while o_in_stall is low; all channels update in parallel
// logic, so the single state update per cycle sets that rate. A two-entry output
// buffer (result register plus skid register) lets a word be accepted while the
// previous result still waits. When the receiver stalls, one more word is taken
// into the skid register, then o_in_stall rises until the receiver takes a word.
// Configuration registers are written through i_cfg_we, i_cfg_idx and i_cfg_data;
// level writes clamp to the top level. The user must write them only while the
// block is idle; the block does not enforce this. Reset (synchronous, active
// low) sets every channel inactive with zero timers and levels, clears the PWM
// counter and drive bits, empties the output buffer and selects active-high drive.
module multi_channel_led_mode_pwm
    import mclp_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int PWM_LEVELS = PWM_LEVELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LW = (PWM_LEVELS > 2) ? $clog2(PWM_LEVELS) : 1;
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [SAT_W-1:0] LEVEL_TOP = SAT_W'(PWM_LEVELS - 1);
    localparam logic [SAT_W-1:0] LEVEL_CNT = SAT_W'(PWM_LEVELS);
    localparam logic [CHAN_SEL_W:0] CHAN_CNT = (CHAN_SEL_W+1)'(CHANNELS);

    // Configuration registers.
    logic [LW-1:0]     r_lvl_active;
    logic [LW-1:0]     r_lvl_inactive;
    logic [LW-1:0]     r_lvl_flash;
    logic [TIME_W-1:0] r_flash_ms;
    logic [TIME_W-1:0] r_toggle_ms;
    logic              r_pol_high;

    // Channel state.
    logic [MODE_W-1:0] r_mode    [CHANNELS];
    logic              r_phase   [CHANNELS];
    logic [TIME_W-1:0] r_elapsed [CHANNELS];
    logic [LW-1:0]     r_level   [CHANNELS];
    logic [LW-1:0]     r_pwm_cnt;
    logic [DRIVE_W-1:0] r_drive;

    logic [MODE_W-1:0] n_mode    [CHANNELS];
    logic              n_phase   [CHANNELS];
    logic [TIME_W-1:0] n_elapsed [CHANNELS];
    logic [LW-1:0]     n_level   [CHANNELS];
    logic [LW-1:0]     n_pwm_cnt;
    logic [DRIVE_W-1:0] n_drive;

    // Output buffer.
    logic      r_out_valid;
    t_out_word r_out;
    logic      r_skd_valid;
    t_out_word r_skd;

    logic          in_acc;
    logic          out_take;
    logic          chan_ok;
    logic [CW-1:0] chan_idx;
    logic [SAT_W-1:0] pwm_inc;
    t_out_word     res;

    assign in_acc   = i_in_valid && !r_skd_valid;
    assign out_take = r_out_valid && !i_out_stall;
    assign chan_ok  = {1'b0, i_in.chan_sel} < CHAN_CNT;
    assign chan_idx = i_in.chan_sel[CW-1:0];
    assign pwm_inc  = SAT_W'(r_pwm_cnt) + SAT_W'(1);

    // Next channel state for the word at the input.
    always_comb begin
        logic [TIME_W-1:0] e1;
        e1 = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            n_mode[i]    = r_mode[i];
            n_phase[i]   = r_phase[i];
            n_elapsed[i] = r_elapsed[i];
            n_level[i]   = r_level[i];
        end
        n_pwm_cnt = r_pwm_cnt;
        n_drive   = r_drive;
        case (i_in.req_type)
            REQ_SET_ONE: begin
                if (chan_ok) begin
                    n_mode[chan_idx]    = i_in.new_mode;
                    n_elapsed[chan_idx] = '0;
                    n_phase[chan_idx]   = 1'b1;
                end
            end
            REQ_SET_ALL: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    n_mode[i]    = i_in.new_mode;
                    n_elapsed[i] = '0;
                    n_phase[i]   = 1'b1;
                end
            end
            REQ_MS_TICK: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    e1 = (r_elapsed[i] == '1) ? r_elapsed[i] : r_elapsed[i] + TIME_W'(1);
                    n_elapsed[i] = e1;
                    case (r_mode[i])
                        MODE_ACTIVE:   n_level[i] = r_lvl_active;
                        MODE_INACTIVE: n_level[i] = r_lvl_inactive;
                        MODE_SINGLE: begin
                            if (e1 < r_flash_ms) begin
                                n_level[i] = r_lvl_flash;
                            end else begin
                                // Blink is over: fall back to inactive, level held.
                                n_mode[i]    = MODE_INACTIVE;
                                n_elapsed[i] = '0;
                                n_phase[i]   = 1'b1;
                            end
                        end
                        default: begin
                            if (e1 >= r_toggle_ms) begin
                                n_elapsed[i] = '0;
                                n_phase[i]   = !r_phase[i];
                            end
                            n_level[i] = n_phase[i] ? r_lvl_flash : r_lvl_inactive;
                        end
                    endcase
                end
            end
            default: begin
                // PWM tick: advance the wrapping counter and compare every channel.
                n_pwm_cnt = (pwm_inc >= LEVEL_CNT) ? '0 : LW'(pwm_inc);
                n_drive   = '0;
                for (int i = 0; i < DRIVE_W; i++) begin
                    if (i < CHANNELS) begin
                        n_drive[i] = (r_level[i] > n_pwm_cnt) ~^ r_pol_high;
                    end
                end
            end
        endcase
    end

    // Result word.
    always_comb begin
        res.led_drive = n_drive;
        res.chan_mode = chan_ok ? n_mode[chan_idx] : MODE_INACTIVE;
    end

    // State, configuration and output buffer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_active   <= '0;
            r_lvl_inactive <= '0;
            r_lvl_flash    <= '0;
            r_flash_ms     <= '0;
            r_toggle_ms    <= '0;
            r_pol_high     <= 1'b1;
            for (int i = 0; i < CHANNELS; i++) begin
                r_mode[i]    <= MODE_INACTIVE;
                r_phase[i]   <= 1'b0;
                r_elapsed[i] <= '0;
                r_level[i]   <= '0;
            end
            r_pwm_cnt   <= '0;
            r_drive     <= '0;
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LEVEL_ACTIVE:
                        r_lvl_active <= LW'(sat_level(i_cfg_data[LEVEL_IN_W-1:0], LEVEL_TOP));
                    CFG_LEVEL_INACTIVE:
                        r_lvl_inactive <= LW'(sat_level(i_cfg_data[LEVEL_IN_W-1:0], LEVEL_TOP));
                    CFG_LEVEL_FLASH:
                        r_lvl_flash <= LW'(sat_level(i_cfg_data[LEVEL_IN_W-1:0], LEVEL_TOP));
                    CFG_FLASH_MS:  r_flash_ms  <= i_cfg_data[TIME_W-1:0];
                    CFG_TOGGLE_MS: r_toggle_ms <= i_cfg_data[TIME_W-1:0];
                    CFG_POLARITY:  r_pol_high  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    r_mode[i]    <= n_mode[i];
                    r_phase[i]   <= n_phase[i];
                    r_elapsed[i] <= n_elapsed[i];
                    r_level[i]   <= n_level[i];
                end
                r_pwm_cnt <= n_pwm_cnt;
                r_drive   <= n_drive;
            end
            if (out_take || !r_out_valid) begin
                if (r_skd_valid) begin
                    r_out       <= r_skd;
                    r_out_valid <= 1'b1;
                    r_skd_valid <= 1'b0;
                end else if (in_acc) begin
                    r_out       <= res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (in_acc) begin
                r_skd       <= res;
                r_skd_valid <= 1'b1;
            end
        end
    end

    assign o_in_stall  = r_skd_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // The skid register only fills behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid register holds a word while the result register is empty");

    // Drive bits change only on a PWM tick.
    a_drive_only_pwm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.req_type != REQ_PWM)) |=> (r_drive == $past(r_drive)))
        else $error("drive bits changed on a word that is not a PWM tick");

    // The PWM counter stays below the level count.
    a_pwm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (SAT_W'(r_pwm_cnt) < LEVEL_CNT))
        else $error("PWM counter out of range");
`endif

endmodule

[tb/sv/multi_channel_led_mode_pwm_tb.sv]
// Self-checking testbench for the multi-channel LED mode PWM block.
module multi_channel_led_mode_pwm_tb;
    import mclp_pkg::*;

    localparam int NCH         = CHANNELS_DEF;
    localparam int NLEVELS     = PWM_LEVELS_DEF;
    localparam int CTR_W       = $clog2(NLEVELS);
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_WORDS = 115;
    localparam logic [LEVEL_IN_W-1:0] TOP_LEVEL = LEVEL_IN_W'(NLEVELS - 1);
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [6] = '{CFG_LEVEL_ACTIVE, CFG_LEVEL_INACTIVE,
        CFG_LEVEL_FLASH, CFG_FLASH_MS, CFG_TOGGLE_MS, CFG_POLARITY};

    // Block ports.
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_word              in_word  = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_word             out_word;

    // Shadow state of the LED controller.
    t_mode                 ch_mode    [NCH];
    logic                  ch_phase   [NCH];
    logic [TIME_W-1:0]     ch_elapsed [NCH];
    logic [LEVEL_IN_W-1:0] ch_level   [NCH];
    logic [CTR_W-1:0]      pwm_ctr;
    logic [DRIVE_W-1:0]    drive_bits;
    logic [LEVEL_IN_W-1:0] lvl_active, lvl_inactive, lvl_flash;
    logic [TIME_W-1:0]     flash_span, toggle_span;
    logic                  drive_high;

    // Words waiting to be sent and results still owed by the block.
    t_in_word  words_to_send [$];
    t_out_word led_words_due [$];
    int        words_queued  = 0;
    int        words_taken   = 0;
    int        results_seen  = 0;
    int        mismatches    = 0;
    logic      in_taken      = 1'b0;
    logic      out_taken     = 1'b0;
    logic      tx_no_gap     = 1'b0;
    logic      rx_no_stall   = 1'b0;
    int        hold_asked    = 0;

    multi_channel_led_mode_pwm #(
        .CHANNELS   (NCH),
        .PWM_LEVELS (NLEVELS)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    task automatic flag_mismatch(input string msg);
        $display("ERROR: %s", msg);
        mismatches++;
    endtask

    function automatic logic [LEVEL_IN_W-1:0] clamp_level(input logic [CFG_DATA_W-1:0] d);
        return (d[LEVEL_IN_W-1:0] > TOP_LEVEL) ? TOP_LEVEL : d[LEVEL_IN_W-1:0];
    endfunction

    // A new mode restarts the channel's timer with its phase on.
    function automatic void relaunch(input int c, input t_mode m);
        ch_mode[c]    = m;
        ch_elapsed[c] = '0;
        ch_phase[c]   = 1'b1;
    endfunction

    // Apply one request word to the shadow state and return the result word.
    function automatic t_out_word step_leds(input t_in_word w);
        t_out_word r;
        case (t_req'(w.req_type))
            REQ_SET_ONE: begin
                if (int'(w.chan_sel) < NCH) relaunch(int'(w.chan_sel), t_mode'(w.new_mode));
            end
            REQ_SET_ALL: begin
                for (int c = 0; c < NCH; c++) relaunch(c, t_mode'(w.new_mode));
            end
            REQ_MS_TICK: begin
                for (int c = 0; c < NCH; c++) begin
                    if (ch_elapsed[c] != '1) ch_elapsed[c] = ch_elapsed[c] + 1'b1;
                    case (ch_mode[c])
                        MODE_ACTIVE:   ch_level[c] = lvl_active;
                        MODE_INACTIVE: ch_level[c] = lvl_inactive;
                        MODE_SINGLE: begin
                            // An expired blink keeps its level until the next tick.
                            if (ch_elapsed[c] < flash_span) ch_level[c] = lvl_flash;
                            else relaunch(c, MODE_INACTIVE);
                        end
                        default: begin
                            if (ch_elapsed[c] >= toggle_span) begin
                                ch_elapsed[c] = '0;
                                ch_phase[c]   = ~ch_phase[c];
                            end
                            ch_level[c] = ch_phase[c] ? lvl_flash : lvl_inactive;
                        end
                    endcase
                end
            end
            default: begin
                pwm_ctr = (int'(pwm_ctr) == NLEVELS - 1) ? '0 : pwm_ctr + 1'b1;
                drive_bits = '0;
                for (int c = 0; c < NCH && c < DRIVE_W; c++)
                    drive_bits[c] = ((ch_level[c] > pwm_ctr) == drive_high);
            end
        endcase
        r.led_drive = drive_bits;
        r.chan_mode = (int'(w.chan_sel) < NCH) ? ch_mode[int'(w.chan_sel)] : MODE_INACTIVE;
        return r;
    endfunction

    // Scoreboard: check taken results, then track register writes and taken words.
    always @(posedge clk) begin : scoreboard
        t_out_word want;
        in_taken  <= rst_n && in_valid && !in_stall;
        out_taken <= rst_n && out_valid && !out_stall;
        if (!rst_n) begin
            for (int c = 0; c < NCH; c++) begin
                ch_mode[c]    = MODE_INACTIVE;
                ch_phase[c]   = 1'b0;
                ch_elapsed[c] = '0;
                ch_level[c]   = '0;
            end
            pwm_ctr      = '0;
            drive_bits   = '0;
            lvl_active   = '0;
            lvl_inactive = '0;
            lvl_flash    = '0;
            flash_span   = '0;
            toggle_span  = '0;
            drive_high   = 1'b1;
        end else begin
            if (out_valid && !out_stall) begin
                if (led_words_due.size() == 0) begin
                    flag_mismatch($sformatf("result %0d arrived with none expected", results_seen));
                end else begin
                    want = led_words_due.pop_front();
                    if (out_word.led_drive !== want.led_drive)
                        flag_mismatch($sformatf("result %0d led_drive %h, expected %h",
                            results_seen, out_word.led_drive, want.led_drive));
                    if (out_word.chan_mode !== want.chan_mode)
                        flag_mismatch($sformatf("result %0d chan_mode %0d, expected %0d",
                            results_seen, out_word.chan_mode, want.chan_mode));
                end
                results_seen++;
            end
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_LEVEL_ACTIVE:   lvl_active   = clamp_level(cfg_data);
                    CFG_LEVEL_INACTIVE: lvl_inactive = clamp_level(cfg_data);
                    CFG_LEVEL_FLASH:    lvl_flash    = clamp_level(cfg_data);
                    CFG_FLASH_MS:       flash_span   = cfg_data;
                    CFG_TOGGLE_MS:      toggle_span  = cfg_data;
                    CFG_POLARITY:       drive_high   = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) begin
                led_words_due.push_back(step_leds(in_word));
                words_taken++;
            end
        end
    end

    // Sender: holds a word until taken, then waits a drawn gap before the next.
    always @(negedge clk) begin : sender
        int gap_left;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else if (!in_valid || in_taken) begin
            if (gap_left > 0) begin
                in_valid <= 1'b0;
                gap_left--;
            end else if (words_to_send.size() != 0) begin
                in_word  <= words_to_send.pop_front();
                in_valid <= 1'b1;
                gap_left = tx_no_gap ? 0 : $urandom_range(0, 11);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls a drawn number of cycles after each taken result,
    // or for a long stretch when asked.
    always @(negedge clk) begin : receiver
        int wait_left;
        int hold_done;
        if (hold_asked != hold_done) begin
            hold_done = hold_asked;
            wait_left = LONG_HOLD;
        end else if (out_taken && !rx_no_stall) begin
            wait_left = $urandom_range(0, 11);
        end
        if (wait_left > 0) begin
            out_stall <= 1'b1;
            wait_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog: end the run if no word moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
            else quiet++;
        end
        $display("ERROR: no word moved for %0d cycles", QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void queue_word(input t_req r, input int ch, input t_mode m);
        t_in_word w;
        w.req_type = r;
        w.chan_sel = ch[CHAN_SEL_W-1:0];
        w.new_mode = m;
        words_to_send.push_back(w);
        words_queued++;
    endfunction

    // Mostly ticks, with mode changes sprinkled in; a quarter address absent channels.
    function automatic void queue_random_word();
        int   pick;
        t_req r;
        pick = $urandom_range(0, 99);
        r = (pick < 14) ? REQ_SET_ONE : (pick < 19) ? REQ_SET_ALL :
            (pick < 55) ? REQ_MS_TICK : REQ_PWM;
        queue_word(r, ($urandom_range(0, 3) == 0) ? $urandom_range(NCH, 15)
                                                  : $urandom_range(0, NCH - 1),
                   t_mode'($urandom_range(0, 3)));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_level();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DATA_W'($urandom_range(0, 65535));
            default: return CFG_DATA_W'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_span();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CFG_DATA_W'($urandom_range(1, 9));
        endcase
    endfunction

    // Register writes happen only with the block idle.
    task automatic load_settings(input logic [CFG_DATA_W-1:0] vals [6]);
        for (int k = 0; k < 6; k++) begin
            @(negedge clk);
            cfg_we   <= 1'b1;
            cfg_idx  <= REG_ORDER[k];
            cfg_data <= vals[k];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every queued word is taken and every result has come back.
    task automatic drain();
        do @(negedge clk);
        while (words_taken != words_queued || led_words_due.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] regs [6];
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero levels, active-high drive, every channel inactive.
        queue_word(REQ_PWM, 0, MODE_ACTIVE);
        queue_word(REQ_MS_TICK, 15, MODE_REPEAT);
        queue_word(REQ_PWM, 7, MODE_INACTIVE);
        drain();

        // Directed: oversized level write, each mode, absent channels, both set kinds.
        regs = '{16'hFFFF, 16'h0000, 16'd17, 16'd3, 16'd2, 16'd1};
        load_settings(regs);
        queue_word(REQ_SET_ONE, 0, MODE_ACTIVE);
        queue_word(REQ_SET_ONE, 1, MODE_INACTIVE);
        queue_word(REQ_SET_ONE, 2, MODE_SINGLE);
        queue_word(REQ_SET_ONE, 3, MODE_REPEAT);
        queue_word(REQ_SET_ONE, 8, MODE_ACTIVE);
        queue_word(REQ_SET_ONE, 15, MODE_SINGLE);
        for (int k = 0; k < 4; k++) begin
            queue_word(REQ_MS_TICK, 2 + (k % 2), MODE_ACTIVE);
            queue_word(REQ_PWM, 3 - (k % 2), MODE_REPEAT);
        end
        queue_word(REQ_SET_ALL, 15, MODE_SINGLE);
        queue_word(REQ_MS_TICK, 5, MODE_ACTIVE);
        queue_word(REQ_MS_TICK, 5, MODE_ACTIVE);
        queue_word(REQ_MS_TICK, 5, MODE_ACTIVE);
        queue_word(REQ_PWM, 6, MODE_ACTIVE);
        queue_word(REQ_SET_ALL, 4, MODE_ACTIVE);
        queue_word(REQ_MS_TICK, 7, MODE_INACTIVE);
        queue_word(REQ_PWM, 7, MODE_INACTIVE);
        queue_word(REQ_SET_ALL, 9, MODE_REPEAT);
        queue_word(REQ_MS_TICK, 1, MODE_SINGLE);
        queue_word(REQ_PWM, 1, MODE_SINGLE);
        drain();

        // Random phases: first all settings at their top, then all at zero, then drawn at random.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 0) begin
                regs = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1};
            end else if (ph == 1) begin
                regs = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0};
            end else begin
                regs = '{pick_level(), pick_level(), pick_level(), pick_span(), pick_span(),
                         CFG_DATA_W'($urandom_range(0, 1))};
            end
            load_settings(regs);
            tx_no_gap   = (ph % 3 == 2);
            rx_no_stall = (ph % 3 == 2);
            for (int k = 0; k < PHASE_WORDS; k++) queue_random_word();
            // One phase holds the receiver off long enough to back up the input.
            if (ph == 4) hold_asked++;
            drain();
        end

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
